// ----- rtl/alfr_pkg.sv -----
// Shared constants, seed-one ring table, datapath op codes and
// controller/datapath command and status types. No dependencies.
package alfr_pkg;

    localparam int DEGREE_DEF     = 31;
    localparam int SEPARATION_DEF = 3;
    localparam int TABLE_DEGREE   = 31;
    localparam int IDX_MAX_W      = 6;

    localparam logic [31:0] SCHRAGE_A = 32'd16807;
    localparam logic [31:0] SCHRAGE_R = 32'd2836;
    localparam logic [31:0] SCHRAGE_Q = 32'd127773;
    localparam logic [31:0] SCHRAGE_M = 32'h7FFF_FFFF;
    localparam int          QUO_W     = 15;

    localparam int          RECIP_SHIFT   = 48;
    localparam logic [31:0] SCHRAGE_RECIP =
        32'(((64'd1 << RECIP_SHIFT) + 64'(SCHRAGE_Q) - 64'd1) / 64'(SCHRAGE_Q));

    localparam logic [31:0] SEED_ONE_TABLE [TABLE_DEGREE] = '{
        32'h991539B1, 32'h16A5BCE3, 32'h6774A4CD, 32'h3E01511E, 32'h4E508AAA,
        32'h61048C05, 32'hF5500617, 32'h846B7115, 32'h6A19892C, 32'h896A97AF,
        32'hDB48F936, 32'h14898454, 32'h37FFD106, 32'hB58BFF9C, 32'h59E17104,
        32'hCF918A49, 32'h09378C83, 32'h52C7A471, 32'h8D293EA9, 32'h1F4FC301,
        32'hC3DB71BE, 32'h39B44E1C, 32'hF8A44EF9, 32'h4C8B80B1, 32'h19EDC328,
        32'h87BF4BDD, 32'hC9B240E5, 32'hE9EE4B1B, 32'h4382AEA7, 32'h535B6A41,
        32'hF3BEC3DA
    };

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_SEED_ONE  = 4'd1;
    localparam logic [3:0] OP_SEED_LOAD = 4'd2;
    localparam logic [3:0] OP_COPY      = 4'd3;
    localparam logic [3:0] OP_SEED      = 4'd4;
    localparam logic [3:0] OP_DIV_INIT  = 4'd5;
    localparam logic [3:0] OP_DIV_STEP  = 4'd6;
    localparam logic [3:0] OP_MUL       = 4'd7;
    localparam logic [3:0] OP_FILL      = 4'd8;
    localparam logic [3:0] OP_DRAW      = 4'd9;
    localparam logic [3:0] OP_DIV_REM   = 4'd10;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef struct packed {
        logic [3:0] op;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic copy_last;
        logic fill_last;
        logic warm_last;
    } t_dp_sts;

    function automatic logic [31:0] seed_one_word(input logic [IDX_MAX_W-1:0] idx);
        logic [31:0] word;
        word = '0;
        if (idx < IDX_MAX_W'(TABLE_DEGREE)) begin
            word = SEED_ONE_TABLE[idx[4:0]];
        end
        return word;
    endfunction

endpackage

// ----- rtl/alfr_dpath.sv -----
// Datapath: lag ring memory, front/rear indices, Schrage seed fill unit
// (reciprocal divider and multipliers) and output data register. Uses alfr_pkg.
module alfr_dpath
    import alfr_pkg::*;
#(
    parameter int P_DEGREE     = DEGREE_DEF,
    parameter int P_SEPARATION = SEPARATION_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [31:0] i_seed,
    output logic [30:0] o_random
);

    localparam int AW          = $clog2(P_DEGREE);
    localparam int WARM_N      = 10 * P_DEGREE;
    localparam int WW          = $clog2(WARM_N);
    localparam int FRONT_START = P_SEPARATION % P_DEGREE;
    localparam logic [AW-1:0] LAST_IDX  = AW'(P_DEGREE - 1);
    localparam logic [AW-1:0] FRONT_RST = AW'(FRONT_START);
    localparam logic [WW-1:0] WARM_LAST = WW'(WARM_N - 1);

    logic [31:0]      r_ring [P_DEGREE];
    logic [31:0]      r_rd_front;
    logic [31:0]      r_rd_rear;
    logic [AW-1:0]    r_front;
    logic [AW-1:0]    r_rear;
    logic [AW-1:0]    r_idx;
    logic [WW-1:0]    r_warm;
    logic [31:0]      r_word;
    logic [31:0]      r_rem;
    logic [QUO_W-1:0] r_quo;
    logic             r_neg;
    logic [31:0]      r_p1;
    logic [31:0]      r_p2;
    logic [30:0]      r_out;

    logic [31:0]   sum;
    logic [63:0]   recip_prod;
    logic [31:0]   diff;
    logic [31:0]   fixed;
    logic [AW-1:0] front_next;
    logic [AW-1:0] rear_next;
    logic [AW-1:0] idx_next;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    assign sum        = r_rd_front + r_rd_rear;
    assign recip_prod = 64'(r_rem) * 64'(SCHRAGE_RECIP);
    assign diff       = r_neg ? (r_p2 - r_p1) : (r_p1 - r_p2);
    assign fixed      = diff[31] ? (diff + SCHRAGE_M) : diff;
    assign front_next = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
    assign rear_next  = (r_rear == LAST_IDX) ? '0 : r_rear + AW'(1);
    assign idx_next   = r_idx + AW'(1);

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = fixed;
        unique case (i_cmd.op)
            OP_COPY: begin
                we    = 1'b1;
                wdata = seed_one_word(IDX_MAX_W'(r_idx));
            end
            OP_SEED: begin
                we    = 1'b1;
                waddr = '0;
                wdata = r_word;
            end
            OP_FILL: begin
                we = 1'b1;
            end
            OP_DRAW: begin
                we    = 1'b1;
                waddr = r_front;
                wdata = sum;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_ring[waddr] <= wdata;
        end
        r_rd_front <= r_ring[r_front];
        r_rd_rear  <= r_ring[r_rear];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= FRONT_RST;
            r_rear  <= '0;
        end else if (i_cmd.op == OP_DRAW) begin
            r_front <= front_next;
            r_rear  <= rear_next;
        end else if (i_cmd.op == OP_FILL && r_idx == LAST_IDX) begin
            r_front <= FRONT_RST;
            r_rear  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_SEED_ONE: begin
                r_word <= 32'd1;
                r_idx  <= '0;
            end
            OP_SEED_LOAD: begin
                r_word <= (i_seed == '0) ? 32'd1 : i_seed;
            end
            OP_COPY: begin
                r_idx <= idx_next;
            end
            OP_SEED: begin
                r_idx <= AW'(1);
            end
            OP_DIV_INIT: begin
                r_neg <= r_word[31];
                r_rem <= r_word[31] ? (32'd0 - r_word) : r_word;
            end
            OP_DIV_STEP: begin
                r_quo <= recip_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
            end
            OP_DIV_REM: begin
                r_rem <= r_rem - 32'(r_quo) * SCHRAGE_Q;
            end
            OP_MUL: begin
                r_p1 <= SCHRAGE_A * 32'(r_rem[16:0]);
                r_p2 <= SCHRAGE_R * 32'(r_quo);
            end
            OP_FILL: begin
                r_word <= fixed;
                r_idx  <= idx_next;
                r_warm <= '0;
            end
            OP_DRAW: begin
                r_warm <= r_warm + WW'(1);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
        if (i_cmd.out_load) begin
            r_out <= sum[31:1];
        end
    end

    assign o_sts.copy_last = (r_idx == LAST_IDX);
    assign o_sts.fill_last = (r_idx == LAST_IDX);
    assign o_sts.warm_last = (r_warm == WARM_LAST);
    assign o_random        = r_out;

endmodule

// ----- rtl/alfr_ctrl.sv -----
// Controller: sequences draws, reseed fill, warm-up and reset table load,
// and owns both handshakes. Uses alfr_pkg.
module alfr_ctrl
    import alfr_pkg::*;
#(
    parameter int P_DEGREE = DEGREE_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_cmd,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_COPY  = 4'd1;
    localparam logic [3:0] S_IDLE  = 4'd2;
    localparam logic [3:0] S_DRAW  = 4'd3;
    localparam logic [3:0] S_SEED  = 4'd4;
    localparam logic [3:0] S_ABS   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_FILL  = 4'd8;
    localparam logic [3:0] S_WREAD = 4'd9;
    localparam logic [3:0] S_WADD  = 4'd10;
    localparam logic [3:0] S_REM   = 4'd11;

    localparam logic USE_TABLE = (P_DEGREE == TABLE_DEGREE);

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       in_take;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = OP_SEED_ONE;
                n_state  = USE_TABLE ? S_COPY : S_SEED;
            end
            S_COPY: begin
                o_cmd.op = OP_COPY;
                if (i_sts.copy_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    if (i_in_cmd == CMD_RESEED) begin
                        o_cmd.op = OP_SEED_LOAD;
                        n_state  = S_SEED;
                    end else begin
                        n_state = S_DRAW;
                    end
                end
            end
            S_DRAW: begin
                if (out_free) begin
                    o_cmd.op       = OP_DRAW;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SEED: begin
                o_cmd.op = OP_SEED;
                n_state  = S_ABS;
            end
            S_ABS: begin
                o_cmd.op = OP_DIV_INIT;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_state  = S_REM;
            end
            S_REM: begin
                o_cmd.op = OP_DIV_REM;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_FILL;
            end
            S_FILL: begin
                o_cmd.op = OP_FILL;
                n_state  = i_sts.fill_last ? S_WREAD : S_ABS;
            end
            S_WREAD: begin
                n_state = S_WADD;
            end
            S_WADD: begin
                o_cmd.op = OP_DRAW;
                n_state  = i_sts.warm_last ? S_IDLE : S_WREAD;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/additive_lagged_fibonacci_rng.sv -----
// Top level of the additive lagged Fibonacci generator: stream ports,
// controller and datapath. Uses alfr_pkg, alfr_ctrl, alfr_dpath.
//
// channel   direction  handshake                         payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser=command, tdata=seed_value
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata=random_value
//
// A draw: the ring read port registers the front and rear words, then, once the
// output register is free, the sum is written back and loaded into it.
// A reseed writes the seed word, then runs five steps per fill word with a
// reciprocal-multiply divide, then 10*DEGREE warm-up draws, each a ring read
// followed by a write-back.
// After reset the ring loads the seed-one table (DEGREE 31) or runs a seed-one reseed;
// no input is taken meanwhile. The output register holds a result under stall
// while the next transaction is accepted.
module additive_lagged_fibonacci_rng
    import alfr_pkg::*;
#(
    parameter int P_DEGREE     = DEGREE_DEF,
    parameter int P_SEPARATION = SEPARATION_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] seed_value
    input  logic        i_s_axis_tuser,   // [0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [30:0] random_value, [31] zero
);

    t_dp_cmd     dp_cmd;
    t_dp_sts     dp_sts;
    logic [30:0] random_value;

    alfr_ctrl #(
        .P_DEGREE(P_DEGREE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_cmd   (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .o_out_valid(o_m_axis_tvalid),
        .i_out_ready(i_m_axis_tready),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    alfr_dpath #(
        .P_DEGREE    (P_DEGREE),
        .P_SEPARATION(P_SEPARATION)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .i_seed  (i_s_axis_tdata),
        .o_random(random_value)
    );

    assign o_m_axis_tdata = {1'b0, random_value};

endmodule

// ----- dv/additive_lagged_fibonacci_rng_tb.sv -----
// Self-checking testbench for additive_lagged_fibonacci_rng: draw and reseed streams
// against a scoreboard that keeps its own 31-word lag ring. Depends on alfr_pkg.
module additive_lagged_fibonacci_rng_tb;
    import alfr_pkg::*;

    localparam int RING_LEN       = 31;
    localparam int LAG_SEP        = 3;
    localparam int WARMUP_DRAWS   = 10 * RING_LEN;
    localparam int RANDOM_ITEMS   = 600;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 1300;

    localparam longint PM_MULT  = 16807;
    localparam longint PM_QUOT  = 127773;
    localparam longint PM_REM   = 2836;
    localparam logic [31:0] PM_MOD = 32'h7FFF_FFFF;

    localparam logic [31:0] EDGE_SEEDS [5] = '{
        32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
    };

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE,
        RX_LONG
    } t_rx_mode;

    class alfr_scoreboard;
        logic [31:0] lag_ring [RING_LEN];
        int unsigned front_pos;
        int unsigned rear_pos;
        logic [30:0] expected_values [$];
        int          errors;

        function new();
            lag_ring = '{
                32'h991539B1, 32'h16A5BCE3, 32'h6774A4CD, 32'h3E01511E, 32'h4E508AAA,
                32'h61048C05, 32'hF5500617, 32'h846B7115, 32'h6A19892C, 32'h896A97AF,
                32'hDB48F936, 32'h14898454, 32'h37FFD106, 32'hB58BFF9C, 32'h59E17104,
                32'hCF918A49, 32'h09378C83, 32'h52C7A471, 32'h8D293EA9, 32'h1F4FC301,
                32'hC3DB71BE, 32'h39B44E1C, 32'hF8A44EF9, 32'h4C8B80B1, 32'h19EDC328,
                32'h87BF4BDD, 32'hC9B240E5, 32'hE9EE4B1B, 32'h4382AEA7, 32'h535B6A41,
                32'hF3BEC3DA
            };
            front_pos = LAG_SEP % RING_LEN;
            rear_pos  = 0;
            errors    = 0;
        endfunction

        function logic [30:0] next_draw();
            logic [31:0] sum;
            sum = lag_ring[front_pos] + lag_ring[rear_pos];
            lag_ring[front_pos] = sum;
            front_pos = (front_pos + 1) % RING_LEN;
            rear_pos  = (rear_pos + 1) % RING_LEN;
            return sum[31:1];
        endfunction

        function void reseed(logic [31:0] seed);
            logic [31:0] word;
            longint      s;
            longint      hi;
            longint      lo;
            longint      v;
            word = (seed == 32'd0) ? 32'd1 : seed;
            lag_ring[0] = word;
            for (int i = 1; i < RING_LEN; i++) begin
                s  = longint'($signed(word));
                hi = s / PM_QUOT;
                lo = s % PM_QUOT;
                v  = PM_MULT * lo - PM_REM * hi;
                word = v[31:0];
                if (word[31]) begin
                    word = word + PM_MOD;
                end
                lag_ring[i] = word;
            end
            front_pos = LAG_SEP % RING_LEN;
            rear_pos  = 0;
            for (int n = 0; n < WARMUP_DRAWS; n++) begin
                void'(next_draw());
            end
        endfunction

        function void note_input(logic cmd, logic [31:0] seed);
            if (cmd == CMD_RESEED) begin
                reseed(seed);
            end else begin
                expected_values.push_back(next_draw());
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch @%0t: %s", $realtime, msg);
        endtask

        task check_result(logic [31:0] data);
            logic [30:0] want;
            if (expected_values.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%08h", data));
            end else begin
                want = expected_values.pop_front();
                if (data[30:0] !== want) begin
                    report_mismatch($sformatf("random_value got %08h want %08h",
                                              data[30:0], want));
                end
                if (data[31] !== 1'b0) begin
                    report_mismatch($sformatf("pad bit set, tdata=%08h", data));
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [31:0] seed_value
    logic        i_s_axis_tuser = 1'b0; // [0] command
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // [30:0] random_value, [31] zero

    alfr_scoreboard sb = new();
    int unsigned    burst_left = 0;
    int unsigned    idle_cycles = 0;
    logic [9:0]     rx_cycle = '0;
    t_rx_mode       rx_mode;

    additive_lagged_fibonacci_rng uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        rx_mode = t_rx_mode'(rx_cycle[9:8]);
        case (rx_mode)
            RX_FREE: begin
                i_m_axis_tready <= 1'b1;
            end
            RX_RANDOM: begin
                i_m_axis_tready <= ($urandom_range(0, 99) < 60);
            end
            RX_SPARSE: begin
                i_m_axis_tready <= (rx_cycle[1:0] == 2'd0);
            end
            default: begin
                i_m_axis_tready <= (rx_cycle[4:0] >= 5'd26);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drive one transaction and hold it until accepted.
    task send_item(input logic cmd, input logic [31:0] seed);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= seed;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        sb.note_input(cmd, seed);
    endtask

    // Insert a random gap at burst boundaries, then send.
    task issue_item(input logic cmd, input logic [31:0] seed);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_item(cmd, seed);
    endtask

    task pause_until_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function logic [31:0] pick_seed();
        logic [31:0] seed;
        case ($urandom_range(0, 3))
            0: seed = EDGE_SEEDS[$urandom_range(0, 4)];
            1: seed = $urandom_range(0, 255);
            2: seed = {1'b1, 31'($urandom())};
            default: seed = $urandom();
        endcase
        return seed;
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // published seed-one table, then every reseed corner
        repeat (4) issue_item(CMD_DRAW, 32'h0000_0000);
        issue_item(CMD_DRAW, 32'hFFFF_FFFF);
        issue_item(CMD_RESEED, 32'h0000_0000);
        repeat (2) issue_item(CMD_DRAW, $urandom());
        issue_item(CMD_RESEED, 32'hFFFF_FFFF);
        repeat (2) issue_item(CMD_DRAW, $urandom());
        issue_item(CMD_RESEED, 32'h8000_0000);
        repeat (2) issue_item(CMD_DRAW, $urandom());
        issue_item(CMD_RESEED, 32'h7FFF_FFFF);
        repeat (2) issue_item(CMD_DRAW, $urandom());
        issue_item(CMD_RESEED, 32'h0000_0001);
        repeat (2) issue_item(CMD_DRAW, $urandom());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                pause_until_drained();
            end
            if ($urandom_range(0, 99) < 2) begin
                issue_item(CMD_RESEED, pick_seed());
            end else begin
                issue_item(CMD_DRAW, $urandom());
            end
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
